// File: rtl/ftd_pkg.sv
// Shared types, register indexes and reset values for the free-fall and tumble detector.
package ftd_pkg;

    localparam int ACCEL_WIDTH_DEF = 16;
    localparam int RUN_WIDTH_DEF   = 16;
    localparam int ANGLE_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int COUNT_WIDTH     = 16;
    localparam int TILT_WIDTH      = 15;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FREEFALL_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FREEFALL_SAMPLES   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TUMBLE_THRESHOLD   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TUMBLE_SAMPLES     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COOLDOWN_SAMPLES   = 3'd4;

    localparam logic [CFG_DATA_WIDTH-1:0] FREEFALL_THRESHOLD_RST = 32'd838861;
    localparam logic [COUNT_WIDTH-1:0]    FREEFALL_SAMPLES_RST   = 16'd50;
    localparam logic [TILT_WIDTH-1:0]     TUMBLE_THRESHOLD_RST   = 15'd6000;
    localparam logic [COUNT_WIDTH-1:0]    TUMBLE_SAMPLES_RST     = 16'd100;
    localparam logic [COUNT_WIDTH-1:0]    COOLDOWN_SAMPLES_RST   = 16'd1000;

    localparam logic [1:0] CAUSE_NONE     = 2'd0;
    localparam logic [1:0] CAUSE_FREEFALL = 2'd1;
    localparam logic [1:0] CAUSE_TUMBLE   = 2'd2;

    typedef struct packed {
        logic [CFG_DATA_WIDTH-1:0] freefall_threshold;
        logic [COUNT_WIDTH-1:0]    freefall_samples;
        logic [TILT_WIDTH-1:0]     tumble_threshold;
        logic [COUNT_WIDTH-1:0]    tumble_samples;
        logic [COUNT_WIDTH-1:0]    cooldown_samples;
    } cfg_t;

    typedef struct packed {
        logic low_mag;
        logic high_angle;
        logic flip;
    } feat_t;

endpackage

// File: rtl/freefall_tumble_detector.sv
// Top level of the free-fall and tumble detector.
// Takes one IMU sample per clock and presents its result in the result register: a taken
// request lands in an input register, then the magnitude and angle compares and the run and
// cooldown counter updates feed the result register. A sample can be taken every cycle; with
// m_tready held low the block holds one result and one sample, then stalls.
// Configuration writes take effect at the next clock and belong between runs of samples.
module freefall_tumble_detector
#(
    parameter int ACCEL_WIDTH = ftd_pkg::ACCEL_WIDTH_DEF,
    parameter int RUN_WIDTH   = ftd_pkg::RUN_WIDTH_DEF,
    parameter int IN_BITS     = 3 * ACCEL_WIDTH + 2 * ftd_pkg::ANGLE_WIDTH + 1,
    parameter int IN_W        = ((IN_BITS + 7) / 8) * 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ftd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [ftd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // accel_x, accel_y, accel_z, roll_angle, pitch_angle, flip_active, zero fill
    input  logic [IN_W-1:0]                     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // anomaly, cause[1:0], zero fill
    output logic [7:0]                          m_tdata
);
    import ftd_pkg::*;

    localparam int AY_LO    = ACCEL_WIDTH;
    localparam int AZ_LO    = 2 * ACCEL_WIDTH;
    localparam int ROLL_LO  = 3 * ACCEL_WIDTH;
    localparam int PITCH_LO = ROLL_LO + ANGLE_WIDTH;
    localparam int FLIP_BIT = PITCH_LO + ANGLE_WIDTH;

    cfg_t       cfg;
    feat_t      feat;
    logic       feat_valid;
    logic       take;
    logic       anomaly;
    logic [1:0] cause;

    ftd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ftd_feat #(.ACCEL_WIDTH(ACCEL_WIDTH)) u_feat
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .accel_x     (s_tdata[AY_LO-1:0]),
        .accel_y     (s_tdata[AZ_LO-1:AY_LO]),
        .accel_z     (s_tdata[ROLL_LO-1:AZ_LO]),
        .roll_angle  (s_tdata[PITCH_LO-1:ROLL_LO]),
        .pitch_angle (s_tdata[FLIP_BIT-1:PITCH_LO]),
        .flip_active (s_tdata[FLIP_BIT]),
        .cfg         (cfg),
        .take        (take),
        .feat_valid  (feat_valid),
        .feat        (feat)
    );

    ftd_decide #(.RUN_WIDTH(RUN_WIDTH)) u_decide
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .feat_valid (feat_valid),
        .feat       (feat),
        .cfg        (cfg),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .anomaly    (anomaly),
        .cause      (cause)
    );

    assign m_tdata = {5'b0, cause, anomaly};

endmodule

// File: rtl/ftd_cfg.sv
// Configuration register file written through the plain write port.
module ftd_cfg
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [ftd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [ftd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    output ftd_pkg::cfg_t                          cfg
);
    import ftd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FREEFALL_THRESHOLD: cfg_next.freefall_threshold = cfg_data;
                REG_FREEFALL_SAMPLES:   cfg_next.freefall_samples = cfg_data[COUNT_WIDTH-1:0];
                REG_TUMBLE_THRESHOLD:   cfg_next.tumble_threshold = cfg_data[TILT_WIDTH-1:0];
                REG_TUMBLE_SAMPLES:     cfg_next.tumble_samples = cfg_data[COUNT_WIDTH-1:0];
                REG_COOLDOWN_SAMPLES:   cfg_next.cooldown_samples = cfg_data[COUNT_WIDTH-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freefall_threshold <= FREEFALL_THRESHOLD_RST;
            cfg_reg.freefall_samples   <= FREEFALL_SAMPLES_RST;
            cfg_reg.tumble_threshold   <= TUMBLE_THRESHOLD_RST;
            cfg_reg.tumble_samples     <= TUMBLE_SAMPLES_RST;
            cfg_reg.cooldown_samples   <= COOLDOWN_SAMPLES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ftd_feat.sv
// Input register and per-sample magnitude and angle comparisons.
module ftd_feat
#(
    parameter int ACCEL_WIDTH = ftd_pkg::ACCEL_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ACCEL_WIDTH-1:0]          accel_x,
    input  logic signed [ACCEL_WIDTH-1:0]          accel_y,
    input  logic signed [ACCEL_WIDTH-1:0]          accel_z,
    input  logic signed [ftd_pkg::ANGLE_WIDTH-1:0] roll_angle,
    input  logic signed [ftd_pkg::ANGLE_WIDTH-1:0] pitch_angle,
    input  logic                                   flip_active,
    input  ftd_pkg::cfg_t                          cfg,
    input  logic                                   take,
    output logic                                   feat_valid,
    output ftd_pkg::feat_t                         feat
);
    import ftd_pkg::*;

    localparam int SQ_W  = 2 * ACCEL_WIDTH;
    localparam int MAG_W = SQ_W + 2;
    localparam int CMP_W = (MAG_W > CFG_DATA_WIDTH) ? MAG_W : CFG_DATA_WIDTH;

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [ACCEL_WIDTH-1:0] ax_reg;
    logic signed [ACCEL_WIDTH-1:0] ay_reg;
    logic signed [ACCEL_WIDTH-1:0] az_reg;
    logic signed [ANGLE_WIDTH-1:0] roll_reg;
    logic signed [ANGLE_WIDTH-1:0] pitch_reg;
    logic                          flip_reg;

    logic [ACCEL_WIDTH-1:0] abs_x;
    logic [ACCEL_WIDTH-1:0] abs_y;
    logic [ACCEL_WIDTH-1:0] abs_z;
    logic [SQ_W-1:0]        sq_x;
    logic [SQ_W-1:0]        sq_y;
    logic [SQ_W-1:0]        sq_z;
    logic [MAG_W-1:0]       mag;
    logic [ANGLE_WIDTH-1:0] roll_mag;
    logic [ANGLE_WIDTH-1:0] pitch_mag;
    logic [ANGLE_WIDTH-1:0] tilt;
    logic                   load;

    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ax_reg    <= accel_x;
            ay_reg    <= accel_y;
            az_reg    <= accel_z;
            roll_reg  <= roll_angle;
            pitch_reg <= pitch_angle;
            flip_reg  <= flip_active;
        end
    end

    assign abs_x = ax_reg[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-ax_reg) : ACCEL_WIDTH'(ax_reg);
    assign abs_y = ay_reg[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-ay_reg) : ACCEL_WIDTH'(ay_reg);
    assign abs_z = az_reg[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-az_reg) : ACCEL_WIDTH'(az_reg);

    assign sq_x = SQ_W'(abs_x) * SQ_W'(abs_x);
    assign sq_y = SQ_W'(abs_y) * SQ_W'(abs_y);
    assign sq_z = SQ_W'(abs_z) * SQ_W'(abs_z);
    assign mag  = MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);

    assign roll_mag  = roll_reg[ANGLE_WIDTH-1] ? ANGLE_WIDTH'(-roll_reg)
                                               : ANGLE_WIDTH'(roll_reg);
    assign pitch_mag = pitch_reg[ANGLE_WIDTH-1] ? ANGLE_WIDTH'(-pitch_reg)
                                                : ANGLE_WIDTH'(pitch_reg);
    assign tilt      = (roll_mag >= pitch_mag) ? roll_mag : pitch_mag;

    assign feat_valid      = valid_reg;
    assign feat.low_mag    = CMP_W'(mag) < CMP_W'(cfg.freefall_threshold);
    assign feat.high_angle = tilt > ANGLE_WIDTH'(cfg.tumble_threshold);
    assign feat.flip       = flip_reg;

endmodule

// File: rtl/ftd_decide.sv
// Run and cooldown counters with the result register.
module ftd_decide
#(
    parameter int RUN_WIDTH = ftd_pkg::RUN_WIDTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           feat_valid,
    input  ftd_pkg::feat_t feat,
    input  ftd_pkg::cfg_t  cfg,
    output logic           take,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           anomaly,
    output logic [1:0]     cause
);
    import ftd_pkg::*;

    localparam int CNT_W = (RUN_WIDTH > COUNT_WIDTH) ? RUN_WIDTH : COUNT_WIDTH;
    localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

    logic [RUN_WIDTH-1:0]   ff_run_reg;
    logic [RUN_WIDTH-1:0]   ff_run_next;
    logic [RUN_WIDTH-1:0]   tb_run_reg;
    logic [RUN_WIDTH-1:0]   tb_run_next;
    logic [COUNT_WIDTH-1:0] cooldown_reg;
    logic [COUNT_WIDTH-1:0] cooldown_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic                   anomaly_reg;
    logic                   anomaly_next;
    logic [1:0]             cause_reg;
    logic [1:0]             cause_next;
    logic                   fire;
    logic [RUN_WIDTH-1:0]   ff_inc;
    logic [RUN_WIDTH-1:0]   tb_inc;
    logic                   ff_flag;

    assign take = !res_valid_reg || out_ready;
    assign fire = feat_valid && take;

    assign ff_inc = (ff_run_reg == RUN_MAX) ? RUN_MAX : ff_run_reg + 1'b1;
    assign tb_inc = (tb_run_reg == RUN_MAX) ? RUN_MAX : tb_run_reg + 1'b1;

    always_comb
    begin
        ff_run_next    = ff_run_reg;
        tb_run_next    = tb_run_reg;
        cooldown_next  = cooldown_reg;
        anomaly_next   = anomaly_reg;
        cause_next     = cause_reg;
        res_valid_next = res_valid_reg;
        ff_flag        = 1'b0;
        if (fire)
        begin
            res_valid_next = 1'b1;
            anomaly_next   = 1'b0;
            cause_next     = CAUSE_NONE;
            if (feat.flip)
            begin
                cooldown_next = cfg.cooldown_samples;
            end
            else if (cooldown_reg != '0)
            begin
                cooldown_next = cooldown_reg - 1'b1;
            end
            else
            begin
                if (feat.low_mag)
                begin
                    ff_run_next = ff_inc;
                    ff_flag     = CNT_W'(ff_inc) >= CNT_W'(cfg.freefall_samples);
                end
                else
                begin
                    ff_run_next = '0;
                end
                if (ff_flag)
                begin
                    anomaly_next = 1'b1;
                    cause_next   = CAUSE_FREEFALL;
                end
                else if (feat.high_angle)
                begin
                    tb_run_next = tb_inc;
                    if (CNT_W'(tb_inc) >= CNT_W'(cfg.tumble_samples))
                    begin
                        anomaly_next = 1'b1;
                        cause_next   = CAUSE_TUMBLE;
                    end
                end
                else
                begin
                    tb_run_next = '0;
                end
            end
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_run_reg    <= '0;
            tb_run_reg    <= '0;
            cooldown_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ff_run_reg    <= ff_run_next;
            tb_run_reg    <= tb_run_next;
            cooldown_reg  <= cooldown_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        anomaly_reg <= anomaly_next;
        cause_reg   <= cause_next;
    end

    assign out_valid = res_valid_reg;
    assign anomaly   = anomaly_reg;
    assign cause     = cause_reg;

    a_flag_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (anomaly_reg == (cause_reg != CAUSE_NONE)))
        else $error("anomaly flag disagrees with cause");

    a_flip_loads_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && feat.flip) |=> (cooldown_reg == $past(cfg.cooldown_samples)))
        else $error("cooldown not loaded by flip");

    a_quiet_in_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (feat.flip || cooldown_reg != '0)) |=> !anomaly_reg)
        else $error("anomaly reported during flip or cooldown");

    a_runs_held_in_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (feat.flip || cooldown_reg != '0)) |=> $stable(ff_run_reg) && $stable(tb_run_reg))
        else $error("run counters moved during flip or cooldown");

endmodule
